>>> sv/keypad_password_lock_assert.svh
// ----------------------------------------------------------------------------
// keypad_password_lock_assert.svh
// Assertion macros shared by the keypad lock RTL.
// ----------------------------------------------------------------------------
`ifndef KEYPAD_PASSWORD_LOCK_ASSERT_SVH
`define KEYPAD_PASSWORD_LOCK_ASSERT_SVH

// same-cycle implication, disabled while reset is held
`define KPL_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("keypad lock assertion failed");

// next-cycle implication, disabled while reset is held
`define KPL_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("keypad lock assertion failed");

`endif

>>> sv/kpl_pkg.sv
// ----------------------------------------------------------------------------
// kpl_pkg
// Types and constants of the keypad password lock.
// ----------------------------------------------------------------------------
package kpl_pkg;

    localparam logic [7:0] KEY_NONE   = 8'hFF;
    localparam logic [7:0] KEY_EQUALS = 8'h3D;

    localparam logic [3:0] TRIES_RESET = 4'd3;

    typedef enum logic [2:0] {
        EV_IGNORED = 3'd0,
        EV_DIGIT   = 3'd1,
        EV_STORED  = 3'd2,
        EV_GRANTED = 3'd3,
        EV_WRONG   = 3'd4,
        EV_LOCKED  = 3'd5
    } t_event;

    typedef enum logic [2:0] {
        PH_SET    = 3'b001,
        PH_CHECK  = 3'b010,
        PH_LOCKED = 3'b100
    } t_phase;

endpackage

>>> sv/kpl_ram.sv
// ----------------------------------------------------------------------------
// kpl_ram
// Generic simple dual-port RAM: one write port, one registered read port.
// ----------------------------------------------------------------------------
module kpl_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        // read data holds while no read is issued
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

>>> sv/keypad_password_lock.sv
// ----------------------------------------------------------------------------
// keypad_password_lock
// Keypad combination lock: stores a password, then checks entries against it.
// ----------------------------------------------------------------------------
// Usage:
//  - Input channel (i_valid / o_stall / i_key_code): one key code per
//    transaction. 0xFF (no key) and '=' are ignored but still give a result.
//  - Output channel (o_valid / i_stall / o_event_res ...): exactly one result
//    transaction per input transaction, in order.
//  - Config: i_cfg_we writes i_cfg_data into tries_allowed. Write only while
//    idle; the value is loaded at the next reload of the tries count.
//  - Throughput: one key per cycle while the receiver does not stall. A
//    key is taken into the front register, which starts the password read;
//    compare and state update results load from it into the output register.
//  - Reset (synchronous, i_rst_n low): setting phase, position 0, tries
//    count and tries_allowed at 3, pipeline empty. Password memory is not
//    cleared; every entry is written before the first check.
//  - Receiver stall: the output register holds; the front stage keeps its
//    transaction and o_stall rises once both are full.
// ----------------------------------------------------------------------------
module keypad_password_lock #(
    parameter int NUM_DIGITS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data,
    // input channel
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_key_code,
    // output channel
    output logic       o_valid,
    input  logic       i_stall,
    output logic [2:0] o_event_res,
    output logic [3:0] o_digit_position,
    output logic [7:0] o_entered_key,
    output logic [3:0] o_tries_remaining
);

    localparam int AW = (NUM_DIGITS > 1) ? $clog2(NUM_DIGITS) : 1;
    localparam logic [AW-1:0] LAST_POS = AW'(NUM_DIGITS - 1);

    // ------------------------------------------------------------------
    // Config register
    // ------------------------------------------------------------------
    logic [3:0] r_tries_allowed;
    logic [3:0] reload;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tries_allowed <= kpl_pkg::TRIES_RESET;
        end else if (i_cfg_we) begin
            r_tries_allowed <= i_cfg_data;
        end
    end

    // zero is taken as one: first wrong entry locks
    assign reload = (r_tries_allowed == 4'd0) ? 4'd1 : r_tries_allowed;

    // ------------------------------------------------------------------
    // Handshake / pipeline flow
    // ------------------------------------------------------------------
    logic r_s1_valid;
    logic r_out_valid;
    logic out_adv;      // output register may load
    logic s1_free;      // front stage may take a new key
    logic in_acc;

    assign out_adv = !r_out_valid || !i_stall;
    assign s1_free = !r_s1_valid || out_adv;
    assign o_stall = !s1_free;
    assign in_acc  = i_valid && s1_free;

    // ------------------------------------------------------------------
    // Front stage: position tracking, password write, compare read.
    // Position sequencing does not depend on the compare outcome, so it
    // runs here and the memory address is known at accept time. After a
    // lock the front keeps counting but the back stage ignores it.
    // ------------------------------------------------------------------
    logic [AW-1:0] r_pos;
    logic          r_front_set;    // still collecting the password
    logic          key_ign;
    logic          pos_last;
    logic          ram_we;
    logic [7:0]    ram_rdata;

    assign key_ign  = (i_key_code == kpl_pkg::KEY_NONE) ||
                      (i_key_code == kpl_pkg::KEY_EQUALS);
    assign pos_last = (r_pos == LAST_POS);
    assign ram_we   = in_acc && r_front_set && !key_ign;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_front_set <= 1'b1;
        end else if (in_acc && !key_ign) begin
            r_pos <= pos_last ? '0 : r_pos + AW'(1);
            if (pos_last) begin
                r_front_set <= 1'b0;
            end
        end
    end

    // Writes only happen in the setting phase and reads only matter in
    // checking, so a read that meets a write of the same entry is never used;
    // any read after the last write already sees the new data.
    kpl_ram #(
        .WIDTH (8),
        .DEPTH (NUM_DIGITS)
    ) u_pw_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (r_pos),
        .i_wdata (i_key_code),
        .i_re    (in_acc),
        .i_raddr (r_pos),
        .o_rdata (ram_rdata)
    );

    // front stage pipeline register
    logic [7:0]    r_s1_key;
    logic [AW-1:0] r_s1_pos;
    logic          r_s1_ign;
    logic          r_s1_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_free) begin
            r_s1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_s1_key  <= i_key_code;
            r_s1_pos  <= r_pos;
            r_s1_ign  <= key_ign;
            r_s1_last <= pos_last;
        end
    end

    // ------------------------------------------------------------------
    // Back stage: compare, mismatch / tries / phase update, build result
    // ------------------------------------------------------------------
    kpl_pkg::t_phase r_phase, n_phase;
    logic            r_mismatch, n_mismatch;
    logic [3:0]      r_tries_left, n_tries_left;
    kpl_pkg::t_event res_event;
    logic [3:0]      res_pos;
    logic [7:0]      res_key;
    logic [3:0]      res_tries;
    logic            mism;
    logic            back_go;

    assign back_go = r_s1_valid && out_adv;
    assign mism    = r_mismatch || (ram_rdata != r_s1_key);

    always_comb begin
        n_phase      = r_phase;
        n_mismatch   = r_mismatch;
        n_tries_left = r_tries_left;
        res_event    = kpl_pkg::EV_LOCKED;
        res_pos      = 4'd0;
        res_key      = 8'd0;
        res_tries    = 4'd0;
        unique case (r_phase)
            kpl_pkg::PH_SET: begin
                if (r_s1_ign) begin
                    res_event = kpl_pkg::EV_IGNORED;
                    res_tries = r_tries_left;
                end else begin
                    res_pos = 4'(r_s1_pos);
                    res_key = r_s1_key;
                    if (r_s1_last) begin
                        n_phase      = kpl_pkg::PH_CHECK;
                        n_tries_left = reload;
                        res_event    = kpl_pkg::EV_STORED;
                        res_tries    = reload;
                    end else begin
                        res_event = kpl_pkg::EV_DIGIT;
                        res_tries = r_tries_left;
                    end
                end
            end
            kpl_pkg::PH_CHECK: begin
                if (r_s1_ign) begin
                    res_event = kpl_pkg::EV_IGNORED;
                    res_tries = r_tries_left;
                end else begin
                    res_pos = 4'(r_s1_pos);
                    res_key = r_s1_key;
                    if (!r_s1_last) begin
                        n_mismatch = mism;
                        res_event  = kpl_pkg::EV_DIGIT;
                        res_tries  = r_tries_left;
                    end else if (!mism) begin
                        n_tries_left = reload;
                        res_event    = kpl_pkg::EV_GRANTED;
                        res_tries    = reload;
                    end else if (r_tries_left <= 4'd1) begin
                        n_mismatch   = 1'b0;
                        n_tries_left = 4'd0;
                        n_phase      = kpl_pkg::PH_LOCKED;
                        res_event    = kpl_pkg::EV_LOCKED;
                        res_tries    = 4'd0;
                    end else begin
                        n_mismatch   = 1'b0;
                        n_tries_left = r_tries_left - 4'd1;
                        res_event    = kpl_pkg::EV_WRONG;
                        res_tries    = r_tries_left - 4'd1;
                    end
                end
            end
            default: begin
                // locked for good: defaults already give the locked result
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase      <= kpl_pkg::PH_SET;
            r_mismatch   <= 1'b0;
            r_tries_left <= kpl_pkg::TRIES_RESET;
        end else if (back_go) begin
            r_phase      <= n_phase;
            r_mismatch   <= n_mismatch;
            r_tries_left <= n_tries_left;
        end
    end

    // ------------------------------------------------------------------
    // Output register
    // ------------------------------------------------------------------
    kpl_pkg::t_event r_out_event;
    logic [3:0]      r_out_pos;
    logic [7:0]      r_out_key;
    logic [3:0]      r_out_tries;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_adv) begin
            r_out_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (back_go) begin
            r_out_event <= res_event;
            r_out_pos   <= res_pos;
            r_out_key   <= res_key;
            r_out_tries <= res_tries;
        end
    end

    assign o_valid           = r_out_valid;
    assign o_event_res       = r_out_event;
    assign o_digit_position  = r_out_pos;
    assign o_entered_key     = r_out_key;
    assign o_tries_remaining = r_out_tries;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic out_locked;
    logic phase_locked;

    assign out_locked   = o_valid && (o_event_res == kpl_pkg::EV_LOCKED);
    assign phase_locked = (r_phase == kpl_pkg::PH_LOCKED);

`include "keypad_password_lock_assert.svh"

    `KPL_ASSERT_NOW(a_locked_zero_tries, i_clk, i_rst_n, out_locked, o_tries_remaining == 4'd0)
    `KPL_ASSERT_NEXT(a_lock_sticks, i_clk, i_rst_n, phase_locked, phase_locked)
    `KPL_ASSERT_NEXT(a_front_set_once, i_clk, i_rst_n, !r_front_set, !r_front_set)
    `KPL_ASSERT_NOW(a_front_not_ahead, i_clk, i_rst_n, r_front_set, r_phase == kpl_pkg::PH_SET)

endmodule

>>> tb/sv/kpl_result_checker.sv
// ----------------------------------------------------------------------------
// kpl_result_checker
// Watches both channels of the keypad lock, predicts each result and compares.
// ----------------------------------------------------------------------------
// Every accepted key transaction is run through a local copy of the lock state
// and its outcome is queued. Every accepted result transaction is compared
// with the oldest queued outcome. Configuration writes are tracked so the
// tries reload follows the block.
// ----------------------------------------------------------------------------
module kpl_result_checker
    import kpl_pkg::*;
#(
    parameter int NUM_DIGITS = 4
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic [3:0] i_cfg_data,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_key_code,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [2:0] i_event_res,
    input  logic [3:0] i_digit_position,
    input  logic [7:0] i_entered_key,
    input  logic [3:0] i_tries_remaining,
    output int         o_error_count,
    output int         o_outstanding
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        t_event     ev;
        logic [3:0] pos;
        logic [7:0] key;
        logic [3:0] tries;
    } t_lock_outcome;

    // local copy of the lock
    logic [7:0]    stored_digits [NUM_DIGITS];
    logic [3:0]    entry_pos;
    logic          mismatch_seen;
    logic [3:0]    tries_left;
    logic [3:0]    tries_allowed;
    t_phase        lock_phase;

    t_lock_outcome pending_outcomes [$];
    int            error_count = 0;
    int            outstanding = 0;

    assign o_error_count = error_count;
    assign o_outstanding = outstanding;

    function automatic logic [3:0] tries_reload();
        return (tries_allowed == 4'd0) ? 4'd1 : tries_allowed;
    endfunction

    function automatic t_lock_outcome predict_outcome(input logic [7:0] key);
        t_lock_outcome res;
        int            pos;
        bit            last;
        res = '{ev: EV_IGNORED, pos: 4'd0, key: 8'd0, tries: tries_left};
        if (lock_phase != PH_SET && lock_phase != PH_CHECK) begin
            res.ev    = EV_LOCKED;
            res.tries = 4'd0;
            return res;
        end
        if (key == KEY_NONE || key == KEY_EQUALS)
            return res;
        pos = (entry_pos >= NUM_DIGITS) ? 0 : int'(entry_pos);
        last = (pos + 1 >= NUM_DIGITS);
        res.pos = 4'(pos);
        res.key = key;
        if (lock_phase == PH_SET) begin
            stored_digits[pos] = key;
            if (last) begin
                entry_pos  = 4'd0;
                lock_phase = PH_CHECK;
                tries_left = tries_reload();
                res.ev     = EV_STORED;
            end else begin
                entry_pos = 4'(pos + 1);
                res.ev    = EV_DIGIT;
            end
            res.tries = tries_left;
            return res;
        end
        if (stored_digits[pos] != key)
            mismatch_seen = 1'b1;
        if (!last) begin
            entry_pos = 4'(pos + 1);
            res.ev    = EV_DIGIT;
            return res;
        end
        entry_pos = 4'd0;
        if (!mismatch_seen) begin
            tries_left = tries_reload();
            res.ev     = EV_GRANTED;
        end else begin
            mismatch_seen = 1'b0;
            if (tries_left <= 4'd1) begin
                // last try used up: locked for good
                tries_left = 4'd0;
                lock_phase = PH_LOCKED;
                res.ev     = EV_LOCKED;
            end else begin
                tries_left = tries_left - 4'd1;
                res.ev     = EV_WRONG;
            end
        end
        res.tries = tries_left;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_lock_outcome seen;
        t_lock_outcome want;
        if (!i_rst_n) begin
            foreach (stored_digits[i]) stored_digits[i] = 8'd0;
            entry_pos     = 4'd0;
            mismatch_seen = 1'b0;
            tries_allowed = TRIES_RESET;
            tries_left    = TRIES_RESET;
            lock_phase    = PH_SET;
            pending_outcomes.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                seen.ev    = t_event'(i_event_res);
                seen.pos   = i_digit_position;
                seen.key   = i_entered_key;
                seen.tries = i_tries_remaining;
                if (pending_outcomes.size() == 0) begin
                    error_count++;
                    $display("%0t: unexpected result ev=%0d pos=%0d key=%02h tries=%0d",
                             $time, i_event_res, seen.pos, seen.key, seen.tries);
                end else begin
                    want = pending_outcomes.pop_front();
                    if (seen !== want) begin
                        error_count++;
                        $display({"%0t: result mismatch: expected ev=%0d pos=%0d ",
                                  "key=%02h tries=%0d, actual ev=%0d pos=%0d ",
                                  "key=%02h tries=%0d"},
                                 $time, want.ev, want.pos, want.key, want.tries,
                                 i_event_res, seen.pos, seen.key, seen.tries);
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                pending_outcomes.push_back(predict_outcome(i_key_code));
            if (i_cfg_we)
                tries_allowed = i_cfg_data;
        end
        outstanding <= pending_outcomes.size();
    end

endmodule

>>> tb/sv/keypad_password_lock_tb.sv
// ----------------------------------------------------------------------------
// keypad_password_lock_tb
// Self-checking testbench of the keypad password lock.
// ----------------------------------------------------------------------------
// A short directed run stores a password built from edge-value keys and walks
// through digit, wrong, granted and ignored-key outcomes. Six random phases
// follow, each with a tries setting (extremes and zero included) and an
// idling mix shared in pairs, feeding mostly whole entries with stray ignored keys.
// A final phase uses up the tries to lock the block and then keeps keying.
// The checker instance predicts and compares; this module drives stimulus
// and prints the verdict.
// ----------------------------------------------------------------------------
module keypad_password_lock_tb
    import kpl_pkg::*;
;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int DIGITS      = 4;
    localparam int CHUNKS      = 6;
    localparam int CHUNK_ITEMS = 270;
    localparam int HOLD_CYCLES = 80;
    // ~1850 keys in all; this is far beyond any correct run
    localparam int CYCLE_LIMIT = 200000;

    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       i_cfg_we = 1'b0;
    logic [3:0] i_cfg_data = 4'd0;
    logic       i_valid = 1'b0;
    logic       o_stall;
    logic [7:0] i_key_code = 8'd0;
    logic       o_valid;
    logic       i_stall = 1'b0;
    logic [2:0] o_event_res;
    logic [3:0] o_digit_position;
    logic [7:0] o_entered_key;
    logic [3:0] o_tries_remaining;

    int         error_count;
    int         outstanding;
    int         cycle_count = 0;

    // idling mix, in percent of cycles
    int         tx_idle_pct = 15;
    int         rx_idle_pct = 64;
    bit         long_hold_req = 1'b0;

    // what the stimulus knows of the lock: the password, where the current
    // entry stands, and how many wrong entries it can still take
    logic [7:0] password [DIGITS];
    logic [7:0] entry_keys [DIGITS];
    int         entry_idx = 0;
    bit         entry_ok = 1'b1;
    int         wrong_streak = 0;
    logic [3:0] tries_cfg = TRIES_RESET;
    logic [3:0] tries_loaded = TRIES_RESET;
    bit         lock_wanted = 1'b0;

    keypad_password_lock #(
        .NUM_DIGITS (DIGITS)
    ) dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_valid           (i_valid),
        .o_stall           (o_stall),
        .i_key_code        (i_key_code),
        .o_valid           (o_valid),
        .i_stall           (i_stall),
        .o_event_res       (o_event_res),
        .o_digit_position  (o_digit_position),
        .o_entered_key     (o_entered_key),
        .o_tries_remaining (o_tries_remaining)
    );

    kpl_result_checker #(
        .NUM_DIGITS (DIGITS)
    ) checker_i (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_data        (i_cfg_data),
        .i_in_valid        (i_valid),
        .i_in_stall        (o_stall),
        .i_key_code        (i_key_code),
        .i_out_valid       (o_valid),
        .i_out_stall       (i_stall),
        .i_event_res       (o_event_res),
        .i_digit_position  (o_digit_position),
        .i_entered_key     (o_entered_key),
        .i_tries_remaining (o_tries_remaining),
        .o_error_count     (error_count),
        .o_outstanding     (outstanding)
    );

    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    // Receiver: random stall at rx_idle_pct. On request it holds off for a
    // long stretch so the pipeline backs up into o_stall.
    initial begin
        forever begin
            @(posedge i_clk);
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            i_stall <= ($urandom_range(99) < rx_idle_pct);
        end
    end

    // any key the lock takes as a digit
    function automatic logic [7:0] pick_digit_key();
        logic [7:0] k;
        do k = 8'($urandom_range(255)); while (k == KEY_NONE || k == KEY_EQUALS);
        return k;
    endfunction

    // One input transaction. Random gaps first; the payload is held until
    // the block takes it. Returns right after the accepting edge.
    task automatic offer_key(input logic [7:0] key);
        while ($urandom_range(99) < tx_idle_pct) begin
            i_valid    <= 1'b0;
            i_key_code <= 8'($urandom);
            @(posedge i_clk);
        end
        i_valid    <= 1'b1;
        i_key_code <= key;
        do @(posedge i_clk); while (o_stall);
    endtask

    // Next entry: the password, or a wrong one with at least one digit off.
    // Wrong entries are only picked while they cannot lock the block, unless
    // locking is the goal.
    task automatic plan_entry();
        bit go_wrong;
        int p;
        go_wrong = lock_wanted ||
                   (($urandom_range(99) < 45) && (wrong_streak + 1 < tries_loaded));
        entry_ok   = !go_wrong;
        entry_keys = password;
        if (go_wrong) begin
            p = $urandom_range(DIGITS - 1);
            do entry_keys[p] = password[p] ^ 8'($urandom_range(1, 255));
            while (entry_keys[p] == KEY_NONE || entry_keys[p] == KEY_EQUALS);
            for (int i = 0; i < DIGITS; i++)
                if (i != p && $urandom_range(3) == 0)
                    entry_keys[i] = pick_digit_key();
        end
    endtask

    // One digit of the running entry, sometimes preceded by a stray no-key
    // or '=' that the lock should ignore.
    task automatic feed_key();
        if ($urandom_range(99) < 8)
            offer_key($urandom_range(1) ? KEY_NONE : KEY_EQUALS);
        if (entry_idx == 0)
            plan_entry();
        offer_key(entry_keys[entry_idx]);
        entry_idx++;
        if (entry_idx == DIGITS) begin
            entry_idx = 0;
            if (entry_ok) begin
                wrong_streak = 0;
                tries_loaded = (tries_cfg == 4'd0) ? 4'd1 : tries_cfg;
            end else begin
                wrong_streak++;
            end
        end
    endtask

    // Directed entry, right or with one digit flipped at bad_pos.
    task automatic key_in_entry(input bit right, input int bad_pos);
        entry_keys = password;
        if (!right)
            entry_keys[bad_pos] = password[bad_pos] ^ 8'h40;
        for (int i = 0; i < DIGITS; i++)
            offer_key(entry_keys[i]);
    endtask

    // Stop sending and wait until every queued result has come back. The
    // first edge lets the checker count the last accepted key.
    task automatic drain();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (outstanding != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // Only called while drained.
    task automatic write_tries(input logic [3:0] value);
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        tries_cfg = value;
    endtask

    initial begin
        logic [3:0] chunk_tries [CHUNKS];

        chunk_tries[0] = 4'd15;
        chunk_tries[1] = 4'd0;
        chunk_tries[2] = 4'($urandom_range(2, 14));
        chunk_tries[3] = 4'd1;
        chunk_tries[4] = 4'd2;
        chunk_tries[5] = 4'd15;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed part, reset value of tries_allowed (3) ---
        // password from edge values; ignored keys in the setting phase
        password[0] = 8'h00;
        password[1] = 8'hFE;
        password[2] = 8'h80;
        password[3] = 8'h7F;
        offer_key(KEY_NONE);
        offer_key(password[0]);
        offer_key(KEY_EQUALS);
        offer_key(password[1]);
        offer_key(password[2]);
        offer_key(password[3]);       // stored, tries reloaded to 3
        key_in_entry(1'b0, 0);        // wrong at first digit, 2 left
        offer_key(KEY_EQUALS);        // ignored, reports 2
        key_in_entry(1'b1, 0);        // granted, back to 3
        key_in_entry(1'b0, DIGITS - 1);
        offer_key(KEY_NONE);
        key_in_entry(1'b1, 0);
        drain();

        // --- random phases ---
        // new random password is not possible (set once), keep the directed one
        for (int c = 0; c < CHUNKS; c++) begin
            case (c / 2)
                0: begin
                    tx_idle_pct = 15;
                    rx_idle_pct = 64;
                end
                1: begin
                    tx_idle_pct = 64;
                    rx_idle_pct = 15;
                end
                default: begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            // entry may be half typed here: the new value only shows at the
            // next reload
            write_tries(chunk_tries[c]);
            for (int n = 0; n < CHUNK_ITEMS; n++) begin
                // back-pressure burst with the sender never idling
                if (c == 4 && n == 100)
                    long_hold_req = 1'b1;
                feed_key();
            end
            drain();
        end

        // --- use up the tries, then keep keying a locked block ---
        lock_wanted = 1'b1;
        while (wrong_streak < tries_loaded)
            feed_key();
        repeat (20) offer_key(8'($urandom));
        offer_key(KEY_NONE);
        offer_key(KEY_EQUALS);
        drain();

        if (error_count == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule

>>> keypad_password_lock.f
+incdir+sv
sv/kpl_pkg.sv
sv/kpl_ram.sv
sv/keypad_password_lock.sv
tb/sv/kpl_result_checker.sv
tb/sv/keypad_password_lock_tb.sv
